@@ src/pkp_pkg.sv @@
package pkp_pkg;

  localparam int PKP_WINDOW_SIZE = 1024;
  localparam int PKP_PEAK_COUNT  = 5;

  localparam int PART_W    = 32;
  localparam int MAG_W     = 64;
  localparam int BIN_W     = 10;
  localparam int SAMPLE_W  = 18;
  localparam int FREQ_W    = 17;
  localparam int WIN_W     = 24;
  localparam int RANK_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = SAMPLE_W;
  localparam int PROD_W    = BIN_W + SAMPLE_W;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 56;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH   = 2'd2;

  localparam logic [SAMPLE_W-1:0] SAMPLE_RATE_RESET = 18'd44100;
  localparam logic [FREQ_W-1:0]   BAND_LOW_RESET    = 17'd300;
  localparam logic [FREQ_W-1:0]   BAND_HIGH_RESET   = 17'd3000;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [BIN_W-1:0]  bin;
    logic [FREQ_W-1:0] freq;
  } cand_t;

  typedef struct packed {
    logic              valid;
    logic [MAG_W-1:0]  mag;
    logic [BIN_W-1:0]  bin;
    logic [FREQ_W-1:0] freq;
  } peak_t;

  typedef struct packed {
    logic              valid;
    logic [BIN_W-1:0]  bin;
    logic [FREQ_W-1:0] freq;
  } emit_t;

endpackage

@@ src/spectral_top_peak_picker_core.sv @@
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  bins: real, imag, bin index; s_tlast ends a window
// m_*      out  m_tvalid/m_tready  peaks: window, bin, frequency, rank; m_tlast ends a window
// cfg_*    in   cfg_we             register index and write data
//
// One bin is accepted every cycle unless the input stalls; a bin passes the front
// stages (squares and band test, then sum and frequency multiply) before the sorting row.
// At a window end the sorted row is copied into a drain row that sends one peak
// per cycle while the output register is not blocked.
// The input stalls only when a window end reaches the sorting row while the drain row
// still holds peaks of the previous window.
// Reset (rst, synchronous) empties both rows and the pipeline; no clearing pass.
module spectral_top_peak_picker_core
  import pkp_pkg::*;
#(
  parameter int WINDOW_SIZE = PKP_WINDOW_SIZE,
  parameter int PEAK_COUNT  = PKP_PEAK_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // real_part [31:0], imag_part [63:32], bin_index [73:64], zeros above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // window_number [23:0], peak_bin [33:24], peak_frequency_hz [50:34],
  // peak_rank [53:51], zeros above
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  localparam int WS_W     = $clog2(WINDOW_SIZE + 1);
  localparam int LIM_W    = FREQ_W + WS_W;
  localparam int CMP_W    = (PROD_W > LIM_W) ? PROD_W : LIM_W;
  localparam int RECIP_W  = PROD_W + 2;
  localparam int FREQ_SHIFT = PROD_W + $clog2(WINDOW_SIZE);
  localparam longint unsigned RECIP_FULL =
    ((64'd1 << FREQ_SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE);
  localparam logic [RECIP_W-1:0] FREQ_RECIP = RECIP_FULL[RECIP_W-1:0];
  localparam logic [PEAK_COUNT-1:0] VEC_ONE = PEAK_COUNT'(1);

  function automatic logic [PART_W-1:0] abs_part(input logic [PART_W-1:0] x);
    abs_part = x[PART_W-1] ? (~x + PART_W'(1)) : x;
  endfunction

  // Configuration registers
  logic [SAMPLE_W-1:0] sample_rate;
  logic [FREQ_W-1:0]   band_low_hz;
  logic [FREQ_W-1:0]   band_high_hz;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_rate  <= SAMPLE_RATE_RESET;
      band_low_hz  <= BAND_LOW_RESET;
      band_high_hz <= BAND_HIGH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE_RATE: sample_rate  <= cfg_data[SAMPLE_W-1:0];
        REG_BAND_LOW:    band_low_hz  <= cfg_data[FREQ_W-1:0];
        REG_BAND_HIGH:   band_high_hz <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  // Front pipeline
  logic adv;
  logic emit_busy;
  logic emit_load;

  logic              s1_valid;
  logic              s1_last;
  logic              s1_keep;
  logic [MAG_W-1:0]  s1_re_sq;
  logic [MAG_W-1:0]  s1_im_sq;
  logic [BIN_W-1:0]  s1_bin;
  logic [PROD_W-1:0] s1_prod;

  logic  s2_valid;
  logic  s2_last;
  logic  s2_keep;
  cand_t s2_cand;

  logic [PART_W-1:0] in_re_abs;
  logic [PART_W-1:0] in_im_abs;
  logic [BIN_W-1:0]  in_bin;
  logic [PROD_W-1:0] in_prod;
  logic [CMP_W-1:0]  low_lim;
  logic [CMP_W-1:0]  high_lim;
  logic              in_keep;
  logic [PROD_W+RECIP_W-1:0] freq_full;

  assign in_re_abs = abs_part(s_tdata[31:0]);
  assign in_im_abs = abs_part(s_tdata[63:32]);
  assign in_bin    = s_tdata[73:64];
  assign in_prod   = PROD_W'(in_bin) * PROD_W'(sample_rate);
  assign low_lim   = CMP_W'(band_low_hz) * CMP_W'(WINDOW_SIZE);
  assign high_lim  = CMP_W'(band_high_hz) * CMP_W'(WINDOW_SIZE);
  assign in_keep   = (CMP_W'(in_prod) >= low_lim) && (CMP_W'(in_prod) <= high_lim);
  assign freq_full = (PROD_W+RECIP_W)'(s1_prod) * (PROD_W+RECIP_W)'(FREQ_RECIP);

  // A window end must not reach the sorting row while the drain row is busy.
  assign adv      = !(s2_valid && s2_last && emit_busy);
  assign s_tready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last      <= s_tlast;
      s1_keep      <= in_keep;
      s1_re_sq     <= MAG_W'(in_re_abs) * MAG_W'(in_re_abs);
      s1_im_sq     <= MAG_W'(in_im_abs) * MAG_W'(in_im_abs);
      s1_bin       <= in_bin;
      s1_prod      <= in_prod;
      s2_last      <= s1_last;
      s2_keep      <= s1_keep;
      s2_cand.mag  <= s1_re_sq + s1_im_sq;
      s2_cand.bin  <= s1_bin;
      s2_cand.freq <= freq_full[FREQ_SHIFT +: FREQ_W];
    end
  end

  // Sorting row
  logic sort_upd;
  logic sort_clear;
  peak_t sort_entry [PEAK_COUNT];
  peak_t sort_next  [PEAK_COUNT];
  peak_t sort_left  [PEAK_COUNT];
  logic  sort_beat  [PEAK_COUNT];
  logic  sort_lbeat [PEAK_COUNT];
  logic [PEAK_COUNT-1:0] sort_valid;

  assign sort_upd   = adv && s2_valid && s2_keep;
  assign sort_clear = adv && s2_valid && s2_last;
  assign emit_load  = sort_clear;

  // Drain row
  emit_t emit_entry [PEAK_COUNT];
  emit_t emit_right [PEAK_COUNT];
  emit_t emit_init  [PEAK_COUNT];
  logic [PEAK_COUNT-1:0] emit_valid;
  logic out_load;

  genvar i;
  generate
    for (i = 0; i < PEAK_COUNT; i++) begin : g_cell
      if (i == 0) begin : g_first
        assign sort_left[i]  = '0;
        assign sort_lbeat[i] = 1'b0;
      end else begin : g_inner
        assign sort_left[i]  = sort_entry[i-1];
        assign sort_lbeat[i] = sort_beat[i-1];
      end
      if (i == PEAK_COUNT - 1) begin : g_end
        assign emit_right[i] = '0;
      end else begin : g_mid
        assign emit_right[i] = emit_entry[i+1];
      end

      pkp_sort_cell u_sort (
        .clk        (clk),
        .rst        (rst),
        .upd        (sort_upd),
        .clear      (sort_clear),
        .cand       (s2_cand),
        .left_entry (sort_left[i]),
        .left_beat  (sort_lbeat[i]),
        .entry      (sort_entry[i]),
        .beat       (sort_beat[i]),
        .entry_next (sort_next[i])
      );

      assign emit_init[i].valid = sort_next[i].valid;
      assign emit_init[i].bin   = sort_next[i].bin;
      assign emit_init[i].freq  = sort_next[i].freq;

      pkp_emit_cell u_emit (
        .clk         (clk),
        .rst         (rst),
        .load        (emit_load),
        .load_entry  (emit_init[i]),
        .shift       (out_load),
        .right_entry (emit_right[i]),
        .entry       (emit_entry[i])
      );

      assign sort_valid[i] = sort_entry[i].valid;
      assign emit_valid[i] = emit_entry[i].valid;
    end
  endgenerate

  assign emit_busy = |emit_valid;

  logic [WIN_W-1:0]  window_counter;
  logic [WIN_W-1:0]  emit_window;
  logic [RANK_W-1:0] emit_rank;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_counter <= '0;
      emit_rank      <= '0;
    end else begin
      if (emit_load) begin
        window_counter <= window_counter + WIN_W'(1);
        emit_rank      <= '0;
      end else if (out_load) begin
        emit_rank <= emit_rank + RANK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_load) begin
      emit_window <= window_counter;
    end
  end

  // Output register
  assign out_load = emit_valid[0] && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, emit_rank, emit_entry[0].freq, emit_entry[0].bin, emit_window};
      m_tlast <= !emit_right[0].valid;
    end
  end

  // Both rows fill from cell 0 without gaps.
  a_sort_packed: assert property (@(posedge clk) disable iff (rst)
    ((sort_valid & (sort_valid + VEC_ONE)) == '0))
    else $error("sorting row has a gap");

  a_emit_packed: assert property (@(posedge clk) disable iff (rst)
    ((emit_valid & (emit_valid + VEC_ONE)) == '0))
    else $error("drain row has a gap");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    emit_load |-> !emit_busy)
    else $error("drain row loaded while still busy");

  a_clear_row: assert property (@(posedge clk) disable iff (rst)
    emit_load |=> (sort_valid == '0))
    else $error("sorting row not empty after a window end");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    out_load |-> ({1'b0, emit_rank} < (RANK_W+1)'(PEAK_COUNT)))
    else $error("peak rank out of range");

endmodule

@@ src/pkp_sort_cell.sv @@
module pkp_sort_cell
  import pkp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  upd,
  input  logic  clear,
  input  cand_t cand,
  input  peak_t left_entry,
  input  logic  left_beat,
  output peak_t entry,
  output logic  beat,
  output peak_t entry_next
);

  // An empty cell is beaten by any candidate; the list stays sorted, so the
  // beat flags along the row form a run of zeros followed by ones.
  always_comb begin
    beat = !entry.valid || (cand.mag > entry.mag) ||
           ((cand.mag == entry.mag) && (cand.bin < entry.bin));
    entry_next = entry;
    if (upd && beat) begin
      if (left_beat) begin
        entry_next = left_entry;
      end else begin
        entry_next.valid = 1'b1;
        entry_next.mag   = cand.mag;
        entry_next.bin   = cand.bin;
        entry_next.freq  = cand.freq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (clear) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

@@ src/pkp_emit_cell.sv @@
module pkp_emit_cell
  import pkp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  emit_t load_entry,
  input  logic  shift,
  input  emit_t right_entry,
  output emit_t entry
);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (load) begin
      entry <= load_entry;
    end else if (shift) begin
      entry <= right_entry;
    end
  end

endmodule
